/* hw/rtl/c2dag_pkg.sv */
// Package for the conv2d operand address generator.
// Holds tensor shape constants, register indexes and the reciprocal table.
// No dependencies.
package c2dag_pkg;

    localparam int MAX_BATCH      = 16;
    localparam int IN_CHANNELS    = 64;
    localparam int OUT_CHANNELS   = 64;
    localparam int FEATURE_GROUPS = 1;
    localparam int KERNEL_HEIGHT  = 3;
    localparam int KERNEL_WIDTH   = 3;

    localparam int GIN  = (IN_CHANNELS / FEATURE_GROUPS == 0) ? 1 :
                          IN_CHANNELS / FEATURE_GROUPS;
    localparam int GOUT = (OUT_CHANNELS / FEATURE_GROUPS == 0) ? 1 :
                          OUT_CHANNELS / FEATURE_GROUPS;

    localparam int CH_W        = 12;
    localparam int U_W         = 15;
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int ADDR_W      = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_Y        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_X        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_TOP         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_DILATION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_DILATION  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_HEIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_WIDTH     = 3'd7;

    // floor(2^19 / d); zero divisor behaves as one
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] d);
        logic [RECIP_W-1:0] m;
        case (d)
            4'd2:    m = 20'd262144;
            4'd3:    m = 20'd174762;
            4'd4:    m = 20'd131072;
            4'd5:    m = 20'd104857;
            4'd6:    m = 20'd87381;
            4'd7:    m = 20'd74898;
            4'd8:    m = 20'd65536;
            4'd9:    m = 20'd58254;
            4'd10:   m = 20'd52428;
            4'd11:   m = 20'd47662;
            4'd12:   m = 20'd43690;
            4'd13:   m = 20'd40329;
            4'd14:   m = 20'd37449;
            4'd15:   m = 20'd34952;
            default: m = 20'd524288;
        endcase
        return m;
    endfunction

    // absolute input channel for an output channel and group channel
    function automatic logic [CH_W-1:0] in_chan(input logic [5:0] oc,
                                                input logic [5:0] gc);
        int grp;
        grp = 0;
        for (int g = 0; g < FEATURE_GROUPS; g++) begin
            if (32'(oc) >= g * GOUT) grp = g;
        end
        return CH_W'(grp * GIN + 32'(gc));
    endfunction

endpackage

/* hw/rtl/conv2d_operand_address_generator.sv */
// Top level of the conv2d operand address generator: six-stage pipeline.
// Depends on c2dag_pkg.
//
// Takes one tap request per transfer and returns one result per request, in
// order. Throughput is one transfer per clock while m_tready does not hold
// the output. Stage 1 forms the unpadded coordinates, stages 2 and 3 divide
// by the input dilation through a reciprocal multiply and a one-step
// correction, stages 4 to 6 build the linear input address with one multiply
// each. Each stage holds its item while the next is full, so empty stages
// fill even when the output waits. The user must make configuration writes
// only while no request is in flight; the block itself does not enforce it.
module conv2d_operand_address_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [c2dag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [c2dag_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // batch_index[3:0], out_channel[9:4], out_row[19:10], out_col[29:20],
    // tap_row[32:30], tap_col[35:33], group_channel[41:36], zero fill
    input  logic [47:0]                        s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // input_address[31:0], kernel_address[63:32]
    output logic [63:0]                        m_tdata,
    // tap_valid[0]
    output logic [0:0]                         m_tuser
);
    import c2dag_pkg::*;

    typedef struct packed {
        logic [3:0]     b;
        logic [5:0]     oc;
        logic [2:0]     ky;
        logic [2:0]     kx;
        logic [5:0]     gc;
        logic           ok;
        logic           negy;
        logic           negx;
        logic [U_W-1:0] uy;
        logic [U_W-1:0] ux;
    } st1_t;

    typedef struct packed {
        st1_t           base;
        logic [U_W-1:0] qy;
        logic [U_W-1:0] qx;
    } st2_t;

    typedef struct packed {
        logic [3:0]  b;
        logic [5:0]  oc;
        logic [2:0]  ky;
        logic [2:0]  kx;
        logic [5:0]  gc;
        logic        ok;
        logic [10:0] iy;
        logic [10:0] ix;
    } st3_t;

    typedef struct packed {
        logic              ok;
        logic [10:0]       ix;
        logic [CH_W-1:0]   ch;
        logic [14:0]       t1;
        logic [ADDR_W-1:0] ka;
    } st4_t;

    typedef struct packed {
        logic              ok;
        logic [CH_W-1:0]   ch;
        logic [25:0]       t2;
        logic [ADDR_W-1:0] ka;
    } st5_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] ia;
        logic [ADDR_W-1:0] ka;
    } st6_t;

    typedef struct packed {
        logic        ok;
        logic [10:0] coord;
    } axis_t;

    logic [4:0]  stride_y_reg, stride_x_reg;
    logic [3:0]  pad_top_reg, pad_left_reg;
    logic [3:0]  kernel_dilation_reg, input_dilation_reg;
    logic [10:0] input_height_reg, input_width_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    st1_t s1_reg, s1_next;
    st2_t s2_reg, s2_next;
    st3_t s3_reg, s3_next;
    st4_t s4_reg, s4_next;
    st5_t s5_reg, s5_next;
    st6_t s6_reg, s6_next;

    logic [3:0]         d_eff;
    logic [RECIP_W-1:0] recip_m;
    axis_t              ay, ax;

    // finish one axis: correct the quotient, check remainder and range
    function automatic axis_t axis_fix(input logic [U_W-1:0] u,
                                       input logic           neg,
                                       input logic [U_W-1:0] q0,
                                       input logic [3:0]     d,
                                       input logic [10:0]    size);
        logic [U_W-1:0] r;
        logic [U_W-1:0] q;
        logic [U_W-1:0] rem;
        axis_t          res;
        r = u - U_W'(19'(q0) * 19'(d));
        if (r >= U_W'(d)) begin
            q   = q0 + U_W'(1);
            rem = r - U_W'(d);
        end else begin
            q   = q0;
            rem = r;
        end
        res.ok    = !neg && (rem == '0) && (q < U_W'(size));
        res.coord = q[10:0];
        return res;
    endfunction

    assign d_eff   = (input_dilation_reg == 4'd0) ? 4'd1 : input_dilation_reg;
    assign recip_m = recip(d_eff);

    assign rdy6     = !v6_reg || m_tready;
    assign rdy5     = !v5_reg || rdy6;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // stage 1: unpadded coordinates and index checks
    always_comb begin
        logic [16:0] py, px;
        py = 17'(s_tdata[19:10] * stride_y_reg)
           + 17'(s_tdata[32:30] * kernel_dilation_reg) - 17'(pad_top_reg);
        px = 17'(s_tdata[29:20] * stride_x_reg)
           + 17'(s_tdata[35:33] * kernel_dilation_reg) - 17'(pad_left_reg);
        s1_next.b    = s_tdata[3:0];
        s1_next.oc   = s_tdata[9:4];
        s1_next.ky   = s_tdata[32:30];
        s1_next.kx   = s_tdata[35:33];
        s1_next.gc   = s_tdata[41:36];
        s1_next.ok   = (32'(s_tdata[3:0]) < MAX_BATCH)
                    && (32'(s_tdata[9:4]) < OUT_CHANNELS)
                    && (32'(s_tdata[32:30]) < KERNEL_HEIGHT)
                    && (32'(s_tdata[35:33]) < KERNEL_WIDTH)
                    && (32'(s_tdata[41:36]) < GIN);
        s1_next.negy = py[16];
        s1_next.negx = px[16];
        s1_next.uy   = py[U_W-1:0];
        s1_next.ux   = px[U_W-1:0];
    end

    // stage 2: approximate quotient
    always_comb begin
        s2_next.base = s1_reg;
        s2_next.qy   = U_W'((35'(s1_reg.uy) * 35'(recip_m)) >> RECIP_SHIFT);
        s2_next.qx   = U_W'((35'(s1_reg.ux) * 35'(recip_m)) >> RECIP_SHIFT);
    end

    // stage 3: exact quotient and bounds
    always_comb begin
        ay = axis_fix(s2_reg.base.uy, s2_reg.base.negy, s2_reg.qy, d_eff,
                      input_height_reg);
        ax = axis_fix(s2_reg.base.ux, s2_reg.base.negx, s2_reg.qx, d_eff,
                      input_width_reg);
        s3_next.b  = s2_reg.base.b;
        s3_next.oc = s2_reg.base.oc;
        s3_next.ky = s2_reg.base.ky;
        s3_next.kx = s2_reg.base.kx;
        s3_next.gc = s2_reg.base.gc;
        s3_next.ok = s2_reg.base.ok && ay.ok && ax.ok;
        s3_next.iy = ay.coord;
        s3_next.ix = ax.coord;
    end

    // stage 4: row term and kernel address
    always_comb begin
        logic [ADDR_W-1:0] ka;
        ka = ((ADDR_W'(s3_reg.ky) * ADDR_W'(KERNEL_WIDTH) + ADDR_W'(s3_reg.kx))
              * ADDR_W'(GIN) + ADDR_W'(s3_reg.gc)) * ADDR_W'(OUT_CHANNELS)
             + ADDR_W'(s3_reg.oc);
        s4_next.ok = s3_reg.ok;
        s4_next.ix = s3_reg.ix;
        s4_next.ch = in_chan(s3_reg.oc, s3_reg.gc);
        s4_next.t1 = 15'(15'(s3_reg.b) * 15'(input_height_reg) + 15'(s3_reg.iy));
        s4_next.ka = s3_reg.ok ? ka : '0;
    end

    // stage 5: pixel index
    always_comb begin
        s5_next.ok = s4_reg.ok;
        s5_next.ch = s4_reg.ch;
        s5_next.t2 = 26'(26'(s4_reg.t1) * 26'(input_width_reg) + 26'(s4_reg.ix));
        s5_next.ka = s4_reg.ka;
    end

    // stage 6: input address
    always_comb begin
        s6_next.ok = s5_reg.ok;
        s6_next.ia = s5_reg.ok ? ADDR_W'(ADDR_W'(s5_reg.t2) * ADDR_W'(IN_CHANNELS)
                                        + ADDR_W'(s5_reg.ch)) : '0;
        s6_next.ka = s5_reg.ka;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_y_reg        <= 5'd1;
            stride_x_reg        <= 5'd1;
            pad_top_reg         <= 4'd0;
            pad_left_reg        <= 4'd0;
            kernel_dilation_reg <= 4'd1;
            input_dilation_reg  <= 4'd1;
            input_height_reg    <= 11'd1;
            input_width_reg     <= 11'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STRIDE_Y:        stride_y_reg        <= cfg_data[4:0];
                REG_STRIDE_X:        stride_x_reg        <= cfg_data[4:0];
                REG_PAD_TOP:         pad_top_reg         <= cfg_data[3:0];
                REG_PAD_LEFT:        pad_left_reg        <= cfg_data[3:0];
                REG_KERNEL_DILATION: kernel_dilation_reg <= cfg_data[3:0];
                REG_INPUT_DILATION:  input_dilation_reg  <= cfg_data[3:0];
                REG_INPUT_HEIGHT:    input_height_reg    <= cfg_data;
                REG_INPUT_WIDTH:     input_width_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) s1_reg <= s1_next;
        if (rdy2 && v1_reg)   s2_reg <= s2_next;
        if (rdy3 && v2_reg)   s3_reg <= s3_next;
        if (rdy4 && v3_reg)   s4_reg <= s4_next;
        if (rdy5 && v4_reg)   s5_reg <= s5_next;
        if (rdy6 && v5_reg)   s6_reg <= s6_next;
    end

    assign m_tvalid = v6_reg;
    assign m_tdata  = {s6_reg.ka, s6_reg.ia};
    assign m_tuser  = s6_reg.ok;

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("invalid tap carries nonzero address");

    a_coord_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && s3_reg.ok) |->
            (s3_reg.iy < input_height_reg) && (s3_reg.ix < input_width_reg))
        else $error("valid tap outside image");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_tready)
        else $error("empty first stage refuses transfer");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for conv2d_operand_address_generator.
// Directed taps and register settings, then random phases; each result is predicted or given.
// Depends on c2dag_pkg and the block's RTL.
module tb_top;
    import c2dag_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_PHASES = 13;
    localparam int TAPS_PER_PHASE = 100;

    typedef struct packed {
        logic [5:0] group_channel;
        logic [2:0] tap_col;
        logic [2:0] tap_row;
        logic [9:0] out_col;
        logic [9:0] out_row;
        logic [5:0] out_channel;
        logic [3:0] batch_index;
    } tap_req_t;

    typedef struct packed {
        logic        tap_valid;
        logic [31:0] input_address;
        logic [31:0] kernel_address;
    } tap_res_t;

    typedef struct packed {
        logic [4:0]  stride_y;
        logic [4:0]  stride_x;
        logic [3:0]  pad_top;
        logic [3:0]  pad_left;
        logic [3:0]  kernel_dilation;
        logic [3:0]  input_dilation;
        logic [10:0] input_height;
        logic [10:0] input_width;
    } reg_set_t;

    typedef struct packed {
        logic     is_cfg;
        reg_set_t regs;
        tap_req_t tap;
        logic     typed;
        tap_res_t want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [47:0]            s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [63:0]            m_tdata;
    logic [0:0]             m_tuser;

    reg_set_t  regs;
    tap_res_t  taps_due[$];
    stim_row_t dir_rows[$];
    logic      no_gap = 1'b0;
    logic      no_stall = 1'b0;
    int        errors = 0;
    int        n_taps = 0;
    int        n_hits = 0;
    int        n_settings = 0;
    int        idle_cycles = 0;
    int        rx_wait = 0;

    conv2d_operand_address_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // one axis: input coordinate after stride, padding and both dilations
    function automatic logic map_axis(input longint pos, input longint stride,
                                      input longint pad, input longint tap,
                                      input longint kdil, input longint idil,
                                      input longint size, output longint coord);
        longint u;
        longint d;
        coord = 0;
        u = pos * stride - pad + tap * kdil;
        d = (idil == 0) ? 1 : idil;
        if (u % d != 0) return 1'b0;
        coord = u / d;
        return coord >= 0 && coord < size;
    endfunction

    function automatic tap_res_t predict_tap(input tap_req_t t, input reg_set_t c);
        tap_res_t res;
        logic     ok;
        longint   iy;
        longint   ix;
        longint   ia;
        longint   ka;
        res = '0;
        iy = 0;
        ix = 0;
        ok = t.batch_index < MAX_BATCH && t.out_channel < OUT_CHANNELS &&
             t.tap_row < KERNEL_HEIGHT && t.tap_col < KERNEL_WIDTH &&
             t.group_channel < GIN;
        if (ok)
            ok = map_axis(t.out_row, c.stride_y, c.pad_top, t.tap_row,
                          c.kernel_dilation, c.input_dilation, c.input_height, iy);
        if (ok)
            ok = map_axis(t.out_col, c.stride_x, c.pad_left, t.tap_col,
                          c.kernel_dilation, c.input_dilation, c.input_width, ix);
        if (ok) begin
            ia = ((longint'(t.batch_index) * c.input_height + iy) * c.input_width + ix)
                 * IN_CHANNELS + (longint'(t.out_channel) / GOUT) * GIN + t.group_channel;
            ka = ((longint'(t.tap_row) * KERNEL_WIDTH + t.tap_col) * GIN + t.group_channel)
                 * OUT_CHANNELS + t.out_channel;
            res.tap_valid      = 1'b1;
            res.input_address  = ia[31:0];
            res.kernel_address = ka[31:0];
        end
        return res;
    endfunction

    function automatic int spread(input int lo, input int hi, input int top);
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, top);
        return $urandom_range(lo, hi);
    endfunction

    function automatic reg_set_t random_regs();
        reg_set_t c;
        c.stride_y        = 5'(spread(1, 16, 31));
        c.stride_x        = 5'(spread(1, 16, 31));
        c.pad_top         = 4'($urandom_range(0, 15));
        c.pad_left        = 4'($urandom_range(0, 15));
        c.kernel_dilation = 4'(spread(1, 8, 15));
        c.input_dilation  = ($urandom_range(0, 2) == 0) ? 4'd1 : 4'(spread(1, 8, 15));
        case ($urandom_range(0, 2))
            0: begin
                c.input_height = 11'($urandom_range(1, 16));
                c.input_width  = 11'($urandom_range(1, 16));
            end
            1: begin
                c.input_height = 11'($urandom_range(1, 64));
                c.input_width  = 11'($urandom_range(1, 64));
            end
            default: begin
                c.input_height = 11'(spread(1, 1024, 2047));
                c.input_width  = 11'(spread(1, 1024, 2047));
            end
        endcase
        return c;
    endfunction

    // output position whose window lands near a random real pixel
    function automatic logic [9:0] aim_pos(input int stride, input int pad, input int tap,
                                           input int kdil, input int idil, input int size);
        int d;
        int u;
        if (stride == 0 || size == 0 || $urandom_range(0, 3) == 0)
            return 10'($urandom_range(0, 1023));
        d = (idil == 0) ? 1 : idil;
        u = $urandom_range(0, size - 1) * d + pad - tap * kdil;
        if (u < 0) u = 0;
        u = u / stride;
        return (u > 1023) ? 10'd1023 : 10'(u);
    endfunction

    function automatic tap_req_t random_tap(input reg_set_t c);
        tap_req_t t;
        if ($urandom_range(0, 7) == 0) begin
            t = tap_req_t'({$urandom, $urandom});
        end else begin
            t.batch_index   = 4'($urandom);
            t.out_channel   = 6'($urandom);
            t.group_channel = 6'($urandom);
            t.tap_row       = 3'($urandom_range(0, KERNEL_HEIGHT - 1));
            t.tap_col       = 3'($urandom_range(0, KERNEL_WIDTH - 1));
            t.out_row = aim_pos(c.stride_y, c.pad_top, t.tap_row, c.kernel_dilation,
                                c.input_dilation, c.input_height);
            t.out_col = aim_pos(c.stride_x, c.pad_left, t.tap_col, c.kernel_dilation,
                                c.input_dilation, c.input_width);
        end
        return t;
    endfunction

    function automatic stim_row_t cfg_row(input int sy, input int sx, input int pt,
                                          input int pl, input int kd, input int id,
                                          input int h, input int w);
        stim_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.regs = '{5'(sy), 5'(sx), 4'(pt), 4'(pl), 4'(kd), 4'(id), 11'(h), 11'(w)};
        return row;
    endfunction

    function automatic stim_row_t probe(input int b, input int oc, input int r,
                                        input int c, input int ky, input int kx,
                                        input int gc, input logic typed = 1'b0,
                                        input logic hit = 1'b0,
                                        input logic [31:0] ia = '0,
                                        input logic [31:0] ka = '0);
        stim_row_t row;
        row = '0;
        row.tap = '{6'(gc), 3'(kx), 3'(ky), 10'(c), 10'(r), 6'(oc), 4'(b)};
        row.typed = typed;
        row.want = '{hit, ia, ka};
        return row;
    endfunction

    task automatic add_row(input stim_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge aclk);
    endtask

    task automatic apply_regs(input reg_set_t c);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (taps_due.size() != 0);
        put_reg(REG_STRIDE_Y, c.stride_y);
        put_reg(REG_STRIDE_X, c.stride_x);
        put_reg(REG_PAD_TOP, c.pad_top);
        put_reg(REG_PAD_LEFT, c.pad_left);
        put_reg(REG_KERNEL_DILATION, c.kernel_dilation);
        put_reg(REG_INPUT_DILATION, c.input_dilation);
        put_reg(REG_INPUT_HEIGHT, c.input_height);
        put_reg(REG_INPUT_WIDTH, c.input_width);
        cfg_wr_en <= 1'b0;
        regs = c;
        n_settings++;
    endtask

    task automatic send_tap(input tap_req_t t, input logic typed, input tap_res_t want);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, t};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        taps_due.insert(taps_due.size(), typed ? want : predict_tap(t, regs));
        n_taps++;
    endtask

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    // result side: random back-pressure and in-order compare
    always @(posedge aclk) begin
        tap_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (taps_due.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer with nothing expected, actual %h/%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = taps_due.pop_front();
                    if (want.tap_valid) n_hits++;
                    if (m_tuser[0] !== want.tap_valid)
                        report("tap_valid", 32'(want.tap_valid), 32'(m_tuser[0]));
                    if (m_tdata[31:0] !== want.input_address)
                        report("input_address", want.input_address, m_tdata[31:0]);
                    if (m_tdata[63:32] !== want.kernel_address)
                        report("kernel_address", want.kernel_address, m_tdata[63:32]);
                end
                rx_wait = no_stall ? 0 : $urandom_range(0, 9);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, taps_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        regs = '{5'd1, 5'd1, 4'd0, 4'd0, 4'd1, 4'd1, 11'd1, 11'd1};

        // reset values: only the origin tap is inside a 1x1 image
        add_row(probe(0, 0, 0, 0, 0, 0, 0, 1, 1, 32'd0, 32'd0));
        add_row(probe(15, 63, 0, 0, 0, 0, 63, 1, 1, 32'd1023, 32'd4095));
        add_row(probe(5, 7, 0, 0, 2, 0, 1, 1));
        add_row(probe(0, 0, 0, 0, 7, 0, 0, 1));
        add_row(probe(0, 0, 0, 0, 0, 7, 0, 1));
        add_row(probe(0, 0, 0, 0, 3, 3, 0, 1));
        add_row(probe(0, 0, 1023, 0, 0, 0, 0, 1));
        add_row(probe(0, 0, 0, 1023, 0, 0, 0, 1));
        // zero-sized image
        add_row(cfg_row(1, 1, 0, 0, 1, 1, 0, 0));
        add_row(probe(0, 0, 0, 0, 0, 0, 0, 1));
        // strides of 16, largest pads, kernel dilation of 8
        add_row(cfg_row(16, 16, 15, 15, 8, 1, 1024, 1024));
        add_row(probe(3, 9, 1, 1, 0, 0, 5));
        add_row(probe(15, 63, 64, 64, 2, 2, 63));
        add_row(probe(15, 63, 63, 63, 2, 2, 63));
        add_row(probe(1, 2, 0, 0, 1, 1, 3));
        // input dilation: divisible and remainder
        add_row(cfg_row(1, 1, 0, 0, 1, 8, 1024, 1024));
        add_row(probe(2, 4, 8, 16, 0, 0, 6));
        add_row(probe(2, 4, 9, 16, 0, 0, 6));
        // zero stride and dilations
        add_row(cfg_row(0, 0, 0, 0, 0, 0, 5, 5));
        add_row(probe(7, 11, 3, 4, 2, 1, 13));
        add_row(probe(8, 12, 1023, 1023, 1, 2, 14));
        // every register at its field maximum
        add_row(cfg_row(31, 31, 15, 15, 15, 15, 2047, 2047));
        add_row(probe(15, 63, 1023, 1023, 2, 2, 63));
        add_row(probe(15, 63, 1, 1, 1, 1, 63));
        add_row(cfg_row(31, 31, 15, 15, 15, 1, 2047, 2047));
        add_row(probe(15, 63, 66, 66, 0, 0, 63));
        add_row(probe(15, 63, 67, 66, 2, 1, 63));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                apply_regs(dir_rows[i].regs);
            else
                send_tap(dir_rows[i].tap, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_regs(random_regs());
            no_gap   = ($urandom_range(0, 3) == 0);
            no_stall = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < TAPS_PER_PHASE; k++)
                send_tap(random_tap(regs), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (taps_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d tap requests over %0d register settings; %0d landed on pixels",
                 n_taps, n_settings, n_hits);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d field mismatches", errors);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
